// ===== design/wss_pkg.sv =====
package wss_pkg;

   // Item kinds on the request channel.
   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_SCAN = 1'b1;

   // Fixed field widths.
   localparam int unsigned BYTE_W     = 8;
   localparam int unsigned CSR_W      = 6;
   localparam int unsigned INDEX_W    = 5;
   localparam int unsigned RSP_OFFS_W = 32;

   // One pattern position: a byte value and its wildcard mark.
   typedef struct packed {
      logic [BYTE_W-1:0] value;
      logic              wild;
   } pat_entry_type;

   // Controls broadcast to every cell of the chain.
   typedef struct packed {
      logic scan_shift;
      logic region_clear;
      logic pat_shift;
      logic pat_write;
   } cell_ctrl_type;

   // One result item.
   typedef struct packed {
      logic                  found;
      logic [RSP_OFFS_W-1:0] offset;
   } result_type;

   // Pattern rebuild sequencer states.
   typedef enum logic {
      SEQ_IDLE,
      SEQ_SWEEP
   } seq_state_type;

endpackage

// ===== design/wildcard_signature_scan_unit.sv =====
// A result item is registered in the output buffer, or in its skid entry if it stalls.
// Throughput: one item per cycle while req_stall is low; req_stall rises while two
// result items wait on rsp_stall. A pattern_length write copies the clamped length of
// positions into the cell chain, keeping req_stall high while it reads one per cycle.
// Reset (synchronous, active high) clears the window, byte count, report flag and output
// buffer and sets pattern_length to 1; pattern positions stay undefined until loaded.
module wildcard_signature_scan_unit #(
   parameter int unsigned PATTERN_MAX = 32,
   parameter int unsigned OFFSET_BITS = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_kind,
   input  logic [wss_pkg::INDEX_W-1:0]       req_pattern_index,
   input  logic [wss_pkg::BYTE_W-1:0]        req_pattern_value,
   input  logic                              req_pattern_is_wildcard,
   input  logic [wss_pkg::BYTE_W-1:0]        req_data_byte,
   input  logic                              req_end_of_region,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_found,
   output logic [wss_pkg::RSP_OFFS_W-1:0]    rsp_match_offset,
   input  logic                              csr_write_enable,
   input  logic [wss_pkg::CSR_W-1:0]         csr_write_data
);
   import wss_pkg::*;

   localparam int unsigned LEN_W = $clog2(PATTERN_MAX + 1);
   localparam int unsigned IDX_W = $clog2(PATTERN_MAX);

   logic [LEN_W-1:0]       len_ff;
   logic [LEN_W-1:0]       len_in;
   logic [OFFSET_BITS-1:0] count_ff;
   logic [OFFSET_BITS-1:0] count_in;
   logic [OFFSET_BITS-1:0] count_new;
   logic                   reported_ff;
   logic                   reported_in;

   logic                   accept;
   logic                   scan;
   logic                   load;
   logic                   last;
   cell_ctrl_type          ctrl;
   pat_entry_type          load_entry;
   logic [IDX_W-1:0]       load_index;
   pat_entry_type          sweep_entry;
   logic                   sweep_valid;
   logic                   loader_busy;
   logic                   buf_full;

   logic [BYTE_W-1:0]      win [PATTERN_MAX];
   pat_entry_type          pat [PATTERN_MAX];
   logic [PATTERN_MAX-1:0] hits;

   logic                   seen_ok;
   logic                   hit_found;
   logic                   res_valid;
   result_type             res;
   result_type             rsp_data;
   logic [OFFSET_BITS-1:0] diff;
   logic [63:0]            diff_ext;

   // Handshake and item decode.
   assign req_stall = buf_full || loader_busy;
   assign accept    = req_valid && !req_stall;
   assign scan      = accept && (req_kind == KIND_SCAN);
   assign load      = accept && (req_kind == KIND_LOAD);
   assign last      = scan && req_end_of_region;

   assign load_entry.value = req_pattern_value;
   assign load_entry.wild  = req_pattern_is_wildcard;

   // A load lands in the cell that faces its position for the current length.
   assign load_index = IDX_W'(32'(len_ff) - 32'd1 - 32'(req_pattern_index));

   assign ctrl.scan_shift   = scan;
   assign ctrl.region_clear = last;
   assign ctrl.pat_shift    = sweep_valid;
   assign ctrl.pat_write    = load && (32'(req_pattern_index) < 32'(len_ff));

   // Effective pattern length: zero acts as one, oversize acts as the maximum.
   always_comb begin
      len_in = len_ff;
      if (csr_write_enable) begin
         if (csr_write_data == '0) begin
            len_in = LEN_W'(1);
         end else if (32'(csr_write_data) > PATTERN_MAX) begin
            len_in = LEN_W'(PATTERN_MAX);
         end else begin
            len_in = LEN_W'(csr_write_data);
         end
      end
   end

   // Pattern store and the sweep that rebuilds the aligned copy in the cells.
   wss_loader #(
      .PATTERN_MAX (PATTERN_MAX),
      .LEN_W       (LEN_W),
      .IDX_W       (IDX_W)
   ) u_loader (
      .clock       (clock),
      .reset       (reset),
      .wr_en       (load && (32'(req_pattern_index) < PATTERN_MAX)),
      .wr_addr     (IDX_W'(req_pattern_index)),
      .wr_entry    (load_entry),
      .sweep_start (csr_write_enable),
      .sweep_len   (len_ff),
      .sweep_entry (sweep_entry),
      .sweep_valid (sweep_valid),
      .busy        (loader_busy)
   );

   // Chain of compare cells; cell k holds window byte k and pattern position length-1-k.
   for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
      logic [BYTE_W-1:0] byte_prev;
      pat_entry_type     pat_prev;
      if (k == 0) begin : g_head
         assign byte_prev = req_data_byte;
         assign pat_prev  = sweep_entry;
      end else begin : g_body
         assign byte_prev = win[k-1];
         assign pat_prev  = pat[k-1];
      end
      wss_cell #(
         .INDEX (k),
         .LEN_W (LEN_W),
         .IDX_W (IDX_W)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .len        (len_ff),
         .load_index (load_index),
         .load_entry (load_entry),
         .byte_in    (byte_prev),
         .pat_in     (pat_prev),
         .byte_out   (win[k]),
         .pat_out    (pat[k]),
         .hit        (hits[k])
      );
   end

   // Saturating byte count and the match decision for this scan item.
   assign count_new = (&count_ff) ? count_ff : count_ff + 1'b1;
   assign seen_ok   = 65'(count_new) >= 65'(len_ff);
   assign hit_found = !reported_ff && seen_ok && (&hits);
   assign res_valid = scan && (hit_found || (req_end_of_region && !reported_ff));

   assign diff     = count_new - OFFSET_BITS'(len_ff);
   assign diff_ext = 64'(diff);

   assign res.found  = hit_found;
   assign res.offset = hit_found ? diff_ext[RSP_OFFS_W-1:0] : '0;

   // Region state: count and report flag, cleared after the last byte.
   always_comb begin
      count_in    = count_ff;
      reported_in = reported_ff;
      if (last) begin
         count_in    = '0;
         reported_in = 1'b0;
      end else if (scan) begin
         count_in    = count_new;
         reported_in = reported_ff || hit_found;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff      <= LEN_W'(1);
         count_ff    <= '0;
         reported_ff <= 1'b0;
      end else begin
         len_ff      <= len_in;
         count_ff    <= count_in;
         reported_ff <= reported_in;
      end
   end

   // Result buffering toward the response channel.
   wss_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (res_valid),
      .in_data   (res),
      .out_valid (rsp_valid),
      .out_data  (rsp_data),
      .out_stall (rsp_stall),
      .full      (buf_full)
   );

   assign rsp_found        = rsp_data.found;
   assign rsp_match_offset = rsp_data.offset;

endmodule

// ===== design/wss_cell.sv =====
module wss_cell #(
   parameter int unsigned INDEX = 0,
   parameter int unsigned LEN_W = 6,
   parameter int unsigned IDX_W = 5
) (
   input  logic                         clock,
   input  logic                         reset,
   input  wss_pkg::cell_ctrl_type       ctrl,
   input  logic [LEN_W-1:0]             len,
   input  logic [IDX_W-1:0]             load_index,
   input  wss_pkg::pat_entry_type       load_entry,
   input  logic [wss_pkg::BYTE_W-1:0]   byte_in,
   input  wss_pkg::pat_entry_type       pat_in,
   output logic [wss_pkg::BYTE_W-1:0]   byte_out,
   output wss_pkg::pat_entry_type       pat_out,
   output logic                         hit
);
   import wss_pkg::*;

   logic [BYTE_W-1:0] window_ff;
   logic [BYTE_W-1:0] window_in;
   pat_entry_type     pattern_ff;
   pat_entry_type     pattern_in;
   logic              active;

   // The cell takes part in the compare only below the pattern length.
   assign active = 32'(len) > INDEX;

   // The byte this cell holds after the current shift is its neighbor's byte.
   assign hit = !active || pattern_ff.wild || (pattern_ff.value == byte_in);

   // Window byte: shifts on scan items and clears at the end of a region.
   always_comb begin
      window_in = window_ff;
      if (ctrl.region_clear) begin
         window_in = '0;
      end else if (ctrl.scan_shift) begin
         window_in = byte_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
      end else begin
         window_ff <= window_in;
      end
   end

   // Aligned pattern position: written by a load item or shifted during a rebuild.
   always_comb begin
      pattern_in = pattern_ff;
      if (ctrl.pat_write && (load_index == IDX_W'(INDEX))) begin
         pattern_in = load_entry;
      end else if (ctrl.pat_shift) begin
         pattern_in = pat_in;
      end
   end

   always_ff @(posedge clock) begin
      pattern_ff <= pattern_in;
   end

   assign byte_out = window_ff;
   assign pat_out  = pattern_ff;

endmodule

// ===== design/wss_loader.sv =====
module wss_loader #(
   parameter int unsigned PATTERN_MAX = 32,
   parameter int unsigned LEN_W       = 6,
   parameter int unsigned IDX_W       = 5
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   wr_en,
   input  logic [IDX_W-1:0]       wr_addr,
   input  wss_pkg::pat_entry_type wr_entry,
   input  logic                   sweep_start,
   input  logic [LEN_W-1:0]       sweep_len,
   output wss_pkg::pat_entry_type sweep_entry,
   output logic                   sweep_valid,
   output logic                   busy
);
   import wss_pkg::*;

   pat_entry_type pattern_mem [PATTERN_MAX];
   pat_entry_type rd_data_ff;
   logic          rd_valid_ff;
   logic          rd_en;
   seq_state_type state_ff;
   seq_state_type state_in;
   logic [LEN_W-1:0] addr_ff;
   logic [LEN_W-1:0] addr_in;

   // Sweep sequencer: reads positions 0 to length-1 in order.
   always_comb begin
      state_in = state_ff;
      addr_in  = addr_ff;
      rd_en    = 1'b0;
      case (state_ff)
         SEQ_IDLE: begin
            if (sweep_start) begin
               state_in = SEQ_SWEEP;
               addr_in  = '0;
            end
         end
         SEQ_SWEEP: begin
            rd_en = 1'b1;
            if (sweep_start) begin
               addr_in = '0;
            end else if (addr_ff == LEN_W'(sweep_len - 1'b1)) begin
               state_in = SEQ_IDLE;
            end else begin
               addr_in = addr_ff + 1'b1;
            end
         end
         default: begin
            state_in = SEQ_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= SEQ_IDLE;
         addr_ff     <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         addr_ff     <= addr_in;
         rd_valid_ff <= rd_en;
      end
   end

   // Canonical pattern store with a registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         pattern_mem[wr_addr] <= wr_entry;
      end
      if (rd_en) begin
         rd_data_ff <= pattern_mem[addr_ff[IDX_W-1:0]];
      end
   end

   assign sweep_entry = rd_data_ff;
   assign sweep_valid = rd_valid_ff;
   assign busy        = (state_ff != SEQ_IDLE) || rd_valid_ff;

endmodule

// ===== design/wss_out_buf.sv =====
module wss_out_buf (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  wss_pkg::result_type in_data,
   output logic                out_valid,
   output wss_pkg::result_type out_data,
   input  logic                out_stall,
   output logic                full
);
   import wss_pkg::*;

   logic       out_valid_ff;
   logic       out_valid_in;
   result_type out_data_ff;
   result_type out_data_in;
   logic       skid_valid_ff;
   logic       skid_valid_in;
   result_type skid_data_ff;
   result_type skid_data_in;
   logic       pop;

   assign pop = out_valid_ff && !out_stall;

   // Output register with one skid entry behind it.
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (in_valid) begin
         if (!out_valid_ff || pop) begin
            out_valid_in = 1'b1;
            out_data_in  = in_data;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = in_data;
         end
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;
   assign full      = skid_valid_ff;

endmodule

// ===== design/wss_checker.sv =====
module wss_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_stall,
   input logic                           req_kind,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input logic                           rsp_found,
   input logic [wss_pkg::RSP_OFFS_W-1:0] rsp_match_offset,
   input logic                           csr_write_enable
);
   import wss_pkg::*;

   // A stalled result item holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_found)
                                 && $stable(rsp_match_offset))
      else $error("stalled result item changed");

   // A not-found item always carries a zero offset.
   a_notfound_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_match_offset == '0)
      else $error("not-found item with nonzero offset");

   // A length write starts the pattern rebuild, which holds off new items.
   a_cfg_stall: assert property (@(posedge clock) disable iff (reset)
      csr_write_enable |=> req_stall)
      else $error("request not stalled during pattern rebuild");

   // A load item never produces a result item.
   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid && req_valid && !req_stall && (req_kind == KIND_LOAD) |=> !rsp_valid)
      else $error("result item appeared after a load item");

endmodule

bind wildcard_signature_scan_unit wss_checker u_wss_checker (.*);
